// File: hdl/chm_pkg.sv
// Package with shared types, constants and state codes of the chained hash map.
package chm_pkg;
    localparam int POOL_NODES_DEF = 128;
    localparam int BUCKETS_DEF    = 16;

    typedef enum logic [1:0] {
        MODE_GET    = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_ERASE  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        key;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] read_value;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD,
        ST_RDNODE,
        ST_CHECK,
        ST_INS_POP,
        ST_INS_LINK,
        ST_ERASE,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_head;
        logic rd_node;
        logic step;
        logic upd_value;
        logic pop_free;
        logic link_new;
        logic unlink;
        logic respond;
        logic ok;
        logic ret_value;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_mode mode;
        logic  cur_nil;
        logic  key_match;
        logic  pool_empty;
        logic  pool_full;
    } t_sts;
endpackage

// File: hdl/chm_ctrl.sv
// Controller state machine of the chained hash map.
module chm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  chm_pkg::t_sts i_sts,
    output chm_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import chm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_start) n_state = ST_HEAD;
            ST_HEAD:   n_state = ST_RDNODE;
            ST_RDNODE: n_state = ST_CHECK;
            ST_CHECK: begin
                if (i_sts.mode == MODE_NONE) n_state = ST_DONE;
                else if (i_sts.cur_nil) begin
                    if (i_sts.mode == MODE_INSERT && !i_sts.pool_empty)
                        n_state = ST_INS_POP;
                    else n_state = ST_DONE;
                end else if (i_sts.key_match) begin
                    if (i_sts.mode == MODE_ERASE && !i_sts.pool_full) n_state = ST_ERASE;
                    else n_state = ST_DONE;
                end else n_state = ST_RDNODE;
            end
            ST_INS_POP:  n_state = ST_INS_LINK;
            ST_INS_LINK: n_state = ST_DONE;
            ST_ERASE:    n_state = ST_DONE;
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // The result is computed in the CHECK or final update state and shown once.
    always_comb begin
        o_cmd = '0;
        o_busy = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE:   o_cmd.load = i_start;
            ST_HEAD:   o_cmd.rd_head = 1'b1;
            ST_RDNODE: o_cmd.rd_node = 1'b1;
            ST_CHECK: begin
                if (i_sts.mode == MODE_NONE) begin
                    o_cmd.respond = 1'b1;
                end else if (i_sts.cur_nil) begin
                    o_cmd.respond = !(i_sts.mode == MODE_INSERT && !i_sts.pool_empty);
                end else if (i_sts.key_match) begin
                    if (i_sts.mode == MODE_GET) begin
                        o_cmd.respond = 1'b1; o_cmd.ok = 1'b1; o_cmd.ret_value = 1'b1;
                    end else if (i_sts.mode == MODE_INSERT) begin
                        o_cmd.upd_value = 1'b1; o_cmd.respond = 1'b1; o_cmd.ok = 1'b1;
                    end else if (i_sts.pool_full) begin
                        o_cmd.respond = 1'b1;
                    end
                end else o_cmd.step = 1'b1;
            end
            ST_INS_POP:  o_cmd.pop_free = 1'b1;
            ST_INS_LINK: begin
                o_cmd.link_new = 1'b1; o_cmd.respond = 1'b1; o_cmd.ok = 1'b1;
            end
            ST_ERASE: begin
                o_cmd.unlink = 1'b1; o_cmd.respond = 1'b1; o_cmd.ok = 1'b1;
            end
            ST_DONE: ;
            default: ;
        endcase
    end
endmodule

// File: hdl/chm_datapath.sv
// Datapath of the chained hash map: bucket heads, node memories and free stack.
module chm_datapath #(
    parameter int POOL_NODES = chm_pkg::POOL_NODES_DEF,
    parameter int BUCKETS    = chm_pkg::BUCKETS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  chm_pkg::t_req i_req,
    input  chm_pkg::t_cmd i_cmd,
    output chm_pkg::t_sts o_sts,
    output logic          o_valid,
    output chm_pkg::t_rsp o_rsp
);
    import chm_pkg::*;

    localparam int NW = $clog2(POOL_NODES + 1);
    localparam int IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

    logic [NW-1:0] r_head [BUCKETS];
    logic [31:0]   m_key  [POOL_NODES];
    logic [31:0]   m_val  [POOL_NODES];
    logic [NW-1:0] m_next [POOL_NODES];
    logic [IW-1:0] m_free [POOL_NODES];
    logic [BUCKETS-1:0] r_hvalid;

    t_req          r_req;
    logic [BW-1:0] r_bkt;
    logic [NW-1:0] r_cur, r_prev, r_nnext, r_new;
    logic [31:0]   r_nkey;
    logic signed [31:0] r_nval;
    logic [NW-1:0] r_fcount;
    logic [NW-1:0] r_low;
    logic          r_valid;
    t_rsp          r_rsp;
    logic [BW-1:0] n_bkt;
    logic [BW-1:0] w_low;
    logic [NW-1:0] w_head;
    logic [NW-1:0] w_ftop;

    // Bucket index: the low key bits, folded once into the bucket range. With a
    // power-of-two bucket count this is exactly the key modulo the count.
    assign w_low = i_req.key[BW-1:0];

    always_comb begin
        if ({1'b0, w_low} >= (BW+1)'(BUCKETS)) n_bkt = w_low - BW'(BUCKETS);
        else n_bkt = w_low;
    end

    assign w_head = r_hvalid[r_bkt] ? r_head[r_bkt] : NIL;
    assign w_ftop = r_fcount - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid <= '0;
            r_fcount <= NW'(POOL_NODES);
            r_low    <= NW'(POOL_NODES);
            r_valid  <= 1'b0;
        end else begin
            r_valid <= i_cmd.respond;
            if (i_cmd.pop_free) begin
                r_fcount <= r_fcount - 1'b1;
                if (w_ftop < r_low) r_low <= w_ftop;
            end
            if (i_cmd.link_new) r_hvalid[r_bkt] <= 1'b1;
            if (i_cmd.unlink) begin
                r_fcount <= r_fcount + 1'b1;
                if (r_prev == NIL) r_hvalid[r_bkt] <= 1'b1;
            end
        end
    end

    // Free stack: entries below the low-water mark were never popped, so they
    // still hold their own index and are not read from the memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_bkt <= n_bkt;
        end
        if (i_cmd.rd_head) begin
            r_cur  <= w_head;
            r_prev <= NIL;
        end
        if (i_cmd.rd_node && r_cur != NIL) begin
            r_nkey  <= m_key[r_cur[IW-1:0]];
            r_nval  <= m_val[r_cur[IW-1:0]];
            r_nnext <= m_next[r_cur[IW-1:0]];
        end
        if (i_cmd.step) begin
            r_prev <= r_cur;
            r_cur  <= r_nnext;
        end
        if (i_cmd.upd_value) m_val[r_cur[IW-1:0]] <= r_req.value;
        if (i_cmd.pop_free) begin
            if (w_ftop >= r_low)
                r_new <= NW'(m_free[w_ftop[IW-1:0]]);
            else
                r_new <= w_ftop;
        end
        if (i_cmd.link_new) begin
            m_key[r_new[IW-1:0]]  <= r_req.key;
            m_val[r_new[IW-1:0]]  <= r_req.value;
            m_next[r_new[IW-1:0]] <= w_head;
            r_head[r_bkt]         <= r_new;
        end
        if (i_cmd.unlink) begin
            if (r_prev != NIL) m_next[r_prev[IW-1:0]] <= r_nnext;
            else r_head[r_bkt] <= r_nnext;
            m_free[r_fcount[IW-1:0]] <= r_cur[IW-1:0];
        end
        if (i_cmd.respond) begin
            r_rsp.ok         <= i_cmd.ok;
            r_rsp.read_value <= i_cmd.ret_value ? r_nval : 32'sd0;
        end
    end

    assign o_sts.mode       = t_mode'(r_req.mode);
    assign o_sts.cur_nil    = (r_cur == NIL);
    assign o_sts.key_match  = (r_nkey == r_req.key);
    assign o_sts.pool_empty = (r_fcount == '0);
    assign o_sts.pool_full  = (r_fcount == NW'(POOL_NODES));
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;
endmodule

// File: hdl/chained_hash_map.sv
// Top level of the chained hash map: controller plus datapath.
// Usage: drive i_req (mode, key, value) and raise start while busy is low;
// the word is taken at that clock edge. Each request yields exactly one
// response word on o_rsp, marked by o_valid for one cycle; the receiver
// cannot stall it and must take it then.
// A request walks its bucket chain node by node: state RDNODE reads the node
// memories and state CHECK compares the key. An insert of a new key also
// passes through INS_POP and INS_LINK, and an erase that finds its key
// through ERASE, before its response appears.
// busy stays high from acceptance until the response cycle is over, so one
// request is in flight at a time; the next word can be taken in the cycle
// after the response.
// Reset (synchronous, active low) empties every bucket and refills the node
// pool; bucket heads carry valid bits and the free stack uses a low-water
// mark, so no clearing pass is needed and the block is ready right after reset.
module chained_hash_map #(
    parameter int POOL_NODES = chm_pkg::POOL_NODES_DEF,
    parameter int BUCKETS    = chm_pkg::BUCKETS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  chm_pkg::t_req i_req,
    output logic          o_valid,
    output chm_pkg::t_rsp o_rsp
);
    import chm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    chm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_sts(w_sts), .o_cmd(w_cmd), .o_busy(busy)
    );

    chm_datapath #(.POOL_NODES(POOL_NODES), .BUCKETS(BUCKETS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req), .i_cmd(w_cmd),
        .o_sts(w_sts), .o_valid(o_valid), .o_rsp(o_rsp)
    );

    // A response never appears while the block is idle.
    a_rsp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("response without request");

    // An accepted word makes the block busy next cycle.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accept did not raise busy");

    // A failed request never returns a value.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.ok) |-> (o_rsp.read_value == 32'sd0))
        else $error("nonzero value on failure");
endmodule
